### design/edc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package edc_pkg;

  localparam int unsigned YEAR2_W  = 7;
  localparam int unsigned DOY_W    = 9;
  localparam int unsigned FRAC_W   = 32;
  localparam int unsigned YEAR_W   = 12;
  localparam int unsigned MONTH_W  = 4;
  localparam int unsigned MDAY_W   = 5;
  localparam int unsigned HOUR_W   = 5;
  localparam int unsigned MIN_W    = 6;
  localparam int unsigned SEC_W    = 6;

  localparam int unsigned IN_DATA_W  = 48;
  localparam int unsigned OUT_DATA_W = 40;

  localparam logic [YEAR2_W-1:0] PIVOT_YEAR  = 7'd57;
  localparam logic [YEAR_W-1:0]  CENTURY_NEW = 12'd2000;
  localparam logic [YEAR_W-1:0]  CENTURY_OLD = 12'd1900;
  localparam logic [DOY_W-1:0]   YEAR_LEN    = 9'd365;
  localparam logic [DOY_W-1:0]   LEAP_YEAR_LEN = 9'd366;
  localparam int unsigned        NUM_MONTHS  = 12;
  localparam int unsigned        FEB_IDX     = 1;

  // last day number of each month in a common year
  localparam logic [DOY_W-1:0] MONTH_END [NUM_MONTHS] = '{
    9'd31,  9'd59,  9'd90,  9'd120, 9'd151, 9'd181,
    9'd212, 9'd243, 9'd273, 9'd304, 9'd334, 9'd365
  };

  typedef struct packed {
    logic [YEAR_W-1:0]  full_year;
    logic [MONTH_W-1:0] month_number;
    logic [MDAY_W-1:0]  day_of_month;
    logic               date_invalid;
  } date_t;

  typedef struct packed {
    logic [HOUR_W-1:0] hour_of_day;
    logic [MIN_W-1:0]  minute_of_hour;
    logic [SEC_W-1:0]  second_of_minute;
  } tod_t;

endpackage

`default_nettype wire

### design/edc_date.sv
`timescale 1ns / 1ps
`default_nettype none

module edc_date (
  input  wire logic [edc_pkg::YEAR2_W-1:0] year_two_digit,
  input  wire logic [edc_pkg::DOY_W-1:0]   day_of_year,
  output edc_pkg::date_t                   date_o
);
  import edc_pkg::*;

  logic [YEAR_W-1:0]  year;
  logic               leap;
  logic [DOY_W-1:0]   year_len;
  logic               invalid;
  logic [MONTH_W-1:0] cnt;
  logic [DOY_W-1:0]   start;
  logic [DOY_W-1:0]   mday;

  always_comb begin
    if (year_two_digit < PIVOT_YEAR) begin
      year = CENTURY_NEW + {{(YEAR_W-YEAR2_W){1'b0}}, year_two_digit};
    end else begin
      year = CENTURY_OLD + {{(YEAR_W-YEAR2_W){1'b0}}, year_two_digit};
    end
  end

  // both centuries are multiples of 400 or outside the window, so only year mod 4 matters
  assign leap     = (year_two_digit[1:0] == 2'b00);
  assign year_len = leap ? LEAP_YEAR_LEN : YEAR_LEN;
  assign invalid  = (day_of_year == '0) || (day_of_year > year_len);

  // count the months that end before the requested day
  always_comb begin
    cnt = '0;
    for (int m = 0; m < NUM_MONTHS - 1; m++) begin
      if (day_of_year > (MONTH_END[m] + ((leap && (m >= FEB_IDX)) ? 9'd1 : 9'd0))) begin
        cnt = cnt + 4'd1;
      end
    end
  end

  always_comb begin
    if (cnt == '0) begin
      start = '0;
    end else begin
      start = MONTH_END[cnt - 4'd1] +
              ((leap && (cnt > MONTH_W'(FEB_IDX))) ? 9'd1 : 9'd0);
    end
  end

  assign mday = day_of_year - start;

  always_comb begin
    date_o.full_year    = year;
    date_o.date_invalid = invalid;
    if (invalid) begin
      date_o.month_number = '0;
      date_o.day_of_month = '0;
    end else begin
      date_o.month_number = cnt + 4'd1;
      date_o.day_of_month = mday[MDAY_W-1:0];
    end
  end

endmodule

`default_nettype wire

### design/edc_time.sv
`timescale 1ns / 1ps
`default_nettype none

module edc_time (
  input  wire logic [edc_pkg::FRAC_W-1:0] day_fraction,
  output edc_pkg::tod_t                   tod_o
);
  import edc_pkg::*;

  localparam int unsigned P24_W = FRAC_W + HOUR_W;
  localparam int unsigned P60_W = FRAC_W + MIN_W;

  logic [P24_W-1:0] f_ext;
  logic [P24_W-1:0] p24;
  logic [P60_W-1:0] r1_ext;
  logic [P60_W-1:0] p60_min;
  logic [P60_W-1:0] r2_ext;
  logic [P60_W-1:0] p60_sec;

  // x*24 = 16x + 8x; x*60 = 64x - 4x
  assign f_ext   = {{HOUR_W{1'b0}}, day_fraction};
  assign p24     = (f_ext << 4) + (f_ext << 3);
  assign r1_ext  = {{MIN_W{1'b0}}, p24[FRAC_W-1:0]};
  assign p60_min = (r1_ext << 6) - (r1_ext << 2);
  assign r2_ext  = {{MIN_W{1'b0}}, p60_min[FRAC_W-1:0]};
  assign p60_sec = (r2_ext << 6) - (r2_ext << 2);

  assign tod_o.hour_of_day      = p24[P24_W-1:FRAC_W];
  assign tod_o.minute_of_hour   = p60_min[P60_W-1:FRAC_W];
  assign tod_o.second_of_minute = p60_sec[P60_W-1:FRAC_W];

endmodule

`default_nettype wire

### design/epoch_day_to_calendar_date_top.sv
`timescale 1ns / 1ps
`default_nettype none

// Epoch day to calendar date converter.
// Input stream: one request per transfer carrying a two-digit epoch year,
// a day of year and an unsigned Q0.32 fraction of day. Output stream: one
// result per request with the four-digit year, month, day of month, hour,
// minute and second; tuser flags a day number of zero or past year end.
// Each request is captured in an input register, converted by constant
// shift-add logic and the month table, and held in a result register.
// A request passes through the input register and then the result register
// before out_tvalid rises. Throughput is one request per cycle while
// out_tready stays high, set by the two pipeline registers.
// A stalled receiver holds the result stable; the input register keeps
// taking requests until it too is full, then in_tready drops.
// Synchronous reset empties both registers; no further setup is needed.
module epoch_day_to_calendar_date_top (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_tvalid,
  output logic                               in_tready,
  // [6:0] year_two_digit, [15:7] day_of_year, [47:16] day_fraction
  input  wire logic [edc_pkg::IN_DATA_W-1:0] in_tdata,
  output logic                               out_tvalid,
  input  wire logic                          out_tready,
  // [11:0] full_year, [15:12] month_number, [20:16] day_of_month,
  // [25:21] hour_of_day, [31:26] minute_of_hour, [37:32] second_of_minute
  output logic [edc_pkg::OUT_DATA_W-1:0]     out_tdata,
  // [0] date_invalid
  output logic                               out_tuser
);
  import edc_pkg::*;

  logic               s1_valid_r;
  logic               s1_valid_nxt;
  logic [YEAR2_W-1:0] s1_year_r;
  logic [DOY_W-1:0]   s1_doy_r;
  logic [FRAC_W-1:0]  s1_frac_r;
  logic               out_valid_r;
  logic               out_valid_nxt;
  date_t              date_r;
  tod_t               tod_r;
  date_t              date_c;
  tod_t               tod_c;
  logic               s2_ready;
  logic               s1_ready;

  assign s2_ready  = !out_valid_r || out_tready;
  assign s1_ready  = !s1_valid_r || s2_ready;
  assign in_tready = s1_ready;

  assign s1_valid_nxt  = s1_ready ? in_tvalid : s1_valid_r;
  assign out_valid_nxt = s2_ready ? s1_valid_r : out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_ready && in_tvalid) begin
      s1_year_r <= in_tdata[6:0];
      s1_doy_r  <= in_tdata[15:7];
      s1_frac_r <= in_tdata[47:16];
    end
  end

  edc_date u_date (
    .year_two_digit (s1_year_r),
    .day_of_year    (s1_doy_r),
    .date_o         (date_c)
  );

  edc_time u_time (
    .day_fraction (s1_frac_r),
    .tod_o        (tod_c)
  );

  always_ff @(posedge clk) begin
    if (s2_ready && s1_valid_r) begin
      date_r <= date_c;
      tod_r  <= tod_c;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = date_r.date_invalid;
  assign out_tdata  = {2'b00, tod_r.second_of_minute, tod_r.minute_of_hour,
                       tod_r.hour_of_day, date_r.day_of_month,
                       date_r.month_number, date_r.full_year};

endmodule

`default_nettype wire

### design/edc_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module edc_props (
  input wire logic                          clk,
  input wire logic                          rst_n,
  input wire logic                          out_tvalid,
  input wire logic                          out_tready,
  input wire logic [edc_pkg::OUT_DATA_W-1:0] out_tdata,
  input wire logic                          out_tuser
);

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result present right after reset");

  a_hold_stall: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("stalled result changed");

  a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tdata[15:12] == 4'd0 && out_tdata[20:16] == 5'd0)
    else $error("invalid date carries month or day");

  a_valid_date: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser |->
      out_tdata[15:12] != 4'd0 && out_tdata[15:12] < 4'd13 && out_tdata[20:16] != 5'd0)
    else $error("month or day out of range");

  a_time_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |->
      out_tdata[25:21] < 5'd24 && out_tdata[31:26] < 6'd60 && out_tdata[37:32] < 6'd60)
    else $error("time of day out of range");

endmodule

bind epoch_day_to_calendar_date_top edc_props u_edc_props (.*);

`default_nettype wire

### tb/sv/edc_checker.sv
`timescale 1ns / 1ps

module edc_checker (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  input  logic                          in_tready,
  // [6:0] year_two_digit, [15:7] day_of_year, [47:16] day_fraction
  input  logic [edc_pkg::IN_DATA_W-1:0] in_tdata,
  input  logic                          out_tvalid,
  input  logic                          out_tready,
  // [11:0] full_year, [15:12] month_number, [20:16] day_of_month,
  // [25:21] hour_of_day, [31:26] minute_of_hour, [37:32] second_of_minute
  input  logic [edc_pkg::OUT_DATA_W-1:0] out_tdata,
  // [0] date_invalid
  input  logic                          out_tuser,
  output int                            mismatch_count,
  output int                            outstanding
);
  import edc_pkg::*;

  localparam int unsigned DAYS_IN_MONTH [NUM_MONTHS] = '{
    31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31
  };

  typedef struct packed {
    logic [YEAR_W-1:0]  full_year;
    logic [MONTH_W-1:0] month_number;
    logic [MDAY_W-1:0]  day_of_month;
    logic [HOUR_W-1:0]  hour_of_day;
    logic [MIN_W-1:0]   minute_of_hour;
    logic [SEC_W-1:0]   second_of_minute;
    logic               date_invalid;
  } calendar_stamp_t;

  calendar_stamp_t pending_stamps [$];

  function automatic calendar_stamp_t convert_epoch(
    input logic [YEAR2_W-1:0] yy,
    input logic [DOY_W-1:0]   doy,
    input logic [FRAC_W-1:0]  frac
  );
    calendar_stamp_t stamp;
    int unsigned     year;
    bit              leap;
    int unsigned     year_days;
    int unsigned     remaining;
    int unsigned     month_len;
    int unsigned     month_idx;
    bit              found;
    logic [63:0]     scaled;
    int unsigned     secs;
    int unsigned     within_hour;
    year = (yy < PIVOT_YEAR) ? (2000 + yy) : (1900 + yy);
    leap = ((year % 4 == 0) && (year % 100 != 0)) || (year % 400 == 0);
    year_days = leap ? 366 : 365;
    stamp = '0;
    stamp.full_year = year[YEAR_W-1:0];
    if (doy == 0 || doy > year_days) begin
      stamp.date_invalid = 1'b1;
    end else begin
      remaining = {23'd0, doy};
      month_idx = 0;
      found = 1'b0;
      for (int m = 0; m < NUM_MONTHS; m++) begin
        if (!found) begin
          month_len = DAYS_IN_MONTH[m];
          if (m == FEB_IDX && leap) begin
            month_len = 29;
          end
          if (remaining <= month_len) begin
            found = 1'b1;
            month_idx = m;
          end else begin
            remaining -= month_len;
          end
        end
      end
      stamp.month_number = MONTH_W'(month_idx + 1);
      stamp.day_of_month = remaining[MDAY_W-1:0];
    end
    scaled = {32'd0, frac} * 64'd86400;
    secs = scaled[63:32];
    within_hour = secs % 3600;
    stamp.hour_of_day = HOUR_W'(secs / 3600);
    stamp.minute_of_hour = MIN_W'(within_hour / 60);
    stamp.second_of_minute = SEC_W'(within_hour % 60);
    return stamp;
  endfunction

  task automatic compare_field(input string name, input int unsigned exp_val,
                               input int unsigned act_val);
    if (exp_val != act_val) begin
      $error("%s: expected %0d, actual %0d", name, exp_val, act_val);
      mismatch_count++;
    end
  endtask

  initial begin
    mismatch_count = 0;
    outstanding = 0;
  end

  always @(posedge clk) begin
    calendar_stamp_t want;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        if (pending_stamps.size() == 0) begin
          $error("result with no request outstanding: %h", out_tdata);
          mismatch_count++;
        end else begin
          want = pending_stamps.pop_front();
          compare_field("full_year", want.full_year, out_tdata[11:0]);
          compare_field("month_number", want.month_number, out_tdata[15:12]);
          compare_field("day_of_month", want.day_of_month, out_tdata[20:16]);
          compare_field("hour_of_day", want.hour_of_day, out_tdata[25:21]);
          compare_field("minute_of_hour", want.minute_of_hour, out_tdata[31:26]);
          compare_field("second_of_minute", want.second_of_minute, out_tdata[37:32]);
          compare_field("date_invalid", want.date_invalid, out_tuser);
        end
      end
      if (in_tvalid && in_tready) begin
        pending_stamps.push_back(convert_epoch(in_tdata[6:0], in_tdata[15:7],
                                               in_tdata[47:16]));
      end
      outstanding = pending_stamps.size();
    end
  end

endmodule

### tb/sv/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import edc_pkg::*;

  localparam int RANDOM_PER_PHASE = 584;
  localparam int HOLD_CYCLES      = 300;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  out_tuser;

  int mismatch_count;
  int outstanding;
  int tx_idle_pct = 31;
  int rx_idle_pct = 50;
  int phase = 0;
  bit hold_done = 1'b0;

  epoch_day_to_calendar_date_top dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  edc_checker checker_i (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_tvalid      (in_tvalid),
    .in_tready      (in_tready),
    .in_tdata       (in_tdata),
    .out_tvalid     (out_tvalid),
    .out_tready     (out_tready),
    .out_tdata      (out_tdata),
    .out_tuser      (out_tuser),
    .mismatch_count (mismatch_count),
    .outstanding    (outstanding)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("testbench failed");
    $finish;
  end

  task automatic send_request(input logic [YEAR2_W-1:0] yy, input logic [DOY_W-1:0] doy,
                              input logic [FRAC_W-1:0] frac);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {frac, doy, yy};
    do @(posedge clk); while (!in_tready);
  endtask

  task automatic send_random_epochs(input int count);
    logic [YEAR2_W-1:0] yy;
    logic [DOY_W-1:0]   doy;
    for (int i = 0; i < count; i++) begin
      yy = YEAR2_W'(($urandom_range(99) < 5) ? $urandom_range(127) : $urandom_range(99));
      doy = DOY_W'(($urandom_range(99) < 20) ? $urandom_range(511) :
                                                $urandom_range(366, 1));
      send_request(yy, doy, $urandom());
    end
  endtask

  // hold off the receiver once while the sender keeps offering
  initial begin
    wait (rst_n);
    forever begin
      if (phase == 2 && !hold_done) begin
        hold_done = 1'b1;
        repeat (HOLD_CYCLES) begin
          out_tready <= 1'b0;
          @(posedge clk);
        end
      end else begin
        out_tready <= ($urandom_range(99) >= rx_idle_pct);
        @(posedge clk);
      end
    end
  end

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_request(7'd0, 9'd1, 32'h0000_0000);
    send_request(7'd0, 9'd60, 32'hFFFF_FFFF);
    send_request(7'd0, 9'd366, 32'd178956970);
    send_request(7'd0, 9'd367, 32'd178956971);
    send_request(7'd1, 9'd365, 32'd2982616);
    send_request(7'd1, 9'd366, 32'd2982617);
    send_request(7'd1, 9'd59, 32'h7FFF_FFFF);
    send_request(7'd1, 9'd60, 32'h8000_0000);
    send_request(7'd56, 9'd0, 32'd49710);
    send_request(7'd57, 9'd1, 32'd49711);
    send_request(7'd99, 9'd365, 32'hAAAA_AAAA);
    send_request(7'd96, 9'd366, 32'h5555_5555);
    send_request(7'd100, 9'd32, 32'h1234_5678);
    send_request(7'd127, 9'd511, 32'hFFFF_FFFF);
    send_request(7'd0, 9'd511, 32'h0000_0001);
    send_request(7'd55, 9'd335, 32'hF000_0000);
    send_request(7'd4, 9'd336, 32'h0FFF_FFFF);
    send_request(7'd100, 9'd366, 32'd3579139413);

    send_random_epochs(RANDOM_PER_PHASE);
    tx_idle_pct = 50;
    rx_idle_pct = 31;
    phase = 1;
    send_random_epochs(RANDOM_PER_PHASE);
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    phase = 2;
    send_random_epochs(RANDOM_PER_PHASE);
    in_tvalid <= 1'b0;

    @(posedge clk);
    wait (outstanding == 0);
    repeat (8) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

endmodule
